// ===== src/pid_pkg.sv =====
// shared types and constants for the point-in-domain test
// no dependencies
package pid_pkg;

  localparam int PT_W    = 21;  // width of one input coordinate port
  localparam int PK_W    = 63;  // packed xyz register width
  localparam int RAD_W   = 32;
  localparam int SQ_W    = 64;
  localparam int AUX_W   = 48;
  localparam int AUX_HALF = 24;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;
  localparam int T_W     = 33;  // axial fraction, Q.32 in 0..1
  localparam int RND_SH  = 28;  // Q.40 down to Q.12

  typedef enum logic [2:0] {
    KIND_BOX   = 3'd0,
    KIND_PLANE = 3'd1,
    KIND_SPH   = 3'd2,
    KIND_CYL   = 3'd3,
    KIND_CONE  = 3'd4,
    KIND_NONE  = 3'd5
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_KIND   = 3'd0,
    REG_PT_A   = 3'd1,
    REG_PT_B   = 3'd2,
    REG_R_OUT  = 3'd3,
    REG_R_IN   = 3'd4,
    REG_R_OSQ  = 3'd5,
    REG_AUX    = 3'd6
  } reg_idx_t;

endpackage

// ===== src/point_in_domain_test.sv =====
// point-in-domain test, ten-stage pipeline
// depends on pid_pkg
//
// usage
//   in_*  : one beat is a point (x, y, z), signed Q12.8, low COORD_BITS
//           bits used and sign extended
//   out_* : one beat per input beat, out_inside_res = 1 when the point lies
//           inside the configured domain; order is kept
//   cfg_* : plain write port, cfg_index selects the register, write only
//           while the pipeline is empty
// throughput one point per cycle while the receiver takes every beat; the
// pipeline depth is set by the chain of the axis dot product, its
// split 4-way product with the axis scale, the radial vector product and
// the final squares, each given a stage of its own
// reset clears every valid bit and loads the register reset values (domain
// kind never-inside)
// when the receiver stalls, the stall walks back stage by stage: empty
// stages still fill, so in_ready only drops once every stage holds a beat
module point_in_domain_test #(
  parameter int COORD_BITS = 21
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pid_pkg::PT_W-1:0]   in_point_x,
  input  logic [pid_pkg::PT_W-1:0]   in_point_y,
  input  logic [pid_pkg::PT_W-1:0]   in_point_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_inside_res,
  input  logic                       cfg_we,
  input  logic [pid_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pid_pkg::CFG_W-1:0]  cfg_wdata
);
  import pid_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int XW   = CW + 1;           // point minus base
  localparam int PBW  = 2 * CW;           // plane products
  localparam int SQW  = 2 * XW;           // sphere squares
  localparam int SSW  = SQW + 2;
  localparam int BXW  = CW + XW;          // axis products
  localparam int DW   = BXW + 2;          // axis dot sum
  localparam int DMW  = DW - 1;           // magnitude when non-negative
  localparam int DLO  = DMW / 2;
  localparam int DHI  = DMW - DLO;
  localparam int PW   = DMW + AUX_W;
  localparam int BTW  = CW + T_W + 1;
  localparam int VW   = CW + 35;
  localparam int QW   = VW - RND_SH;
  localparam int QQW  = 2 * QW;
  localparam int NS   = 10;

  // configuration registers
  logic [2:0]       kind_r;
  logic [PK_W-1:0]  pt_a_r, pt_b_r;
  logic [RAD_W-1:0] r_out_r, r_in_r;
  logic [SQ_W-1:0]  r_osq_r;
  logic [AUX_W-1:0] aux_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_NONE;
      pt_a_r  <= '0;
      pt_b_r  <= '0;
      r_out_r <= '0;
      r_in_r  <= '0;
      r_osq_r <= '0;
      aux_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KIND:  kind_r  <= cfg_wdata[2:0];
        REG_PT_A:  pt_a_r  <= cfg_wdata[PK_W-1:0];
        REG_PT_B:  pt_b_r  <= cfg_wdata[PK_W-1:0];
        REG_R_OUT: r_out_r <= cfg_wdata[RAD_W-1:0];
        REG_R_IN:  r_in_r  <= cfg_wdata[RAD_W-1:0];
        REG_R_OSQ: r_osq_r <= cfg_wdata;
        REG_AUX:   aux_r   <= cfg_wdata[AUX_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] ca [3];
  logic signed [CW-1:0] cb [3];
  logic signed [CW-1:0] pin [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca[i] = $signed(pt_a_r[i*CW +: CW]);
      cb[i] = $signed(pt_b_r[i*CW +: CW]);
    end
    pin[0] = $signed(in_point_x[CW-1:0]);
    pin[1] = $signed(in_point_y[CW-1:0]);
    pin[2] = $signed(in_point_z[CW-1:0]);
  end

  // stage advance chain, a stage moves when it is empty or the next moves
  logic [NS:1] vld_r;
  logic [NS:1] adv;

  always_comb begin
    adv[NS] = !vld_r[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld_r[NS];

  // stage 1: offsets from the base point and box bounds
  logic signed [CW-1:0] s1_p_r [3];
  logic signed [XW-1:0] s1_x_r [3];
  logic                 s1_box_r;
  logic                 box_nxt;

  always_comb begin
    box_nxt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (pin[i] < ca[i] || pin[i] > cb[i]) box_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_p_r[i] <= pin[i];
        s1_x_r[i] <= XW'(pin[i]) - XW'(ca[i]);
      end
      s1_box_r <= box_nxt;
    end
  end

  // stage 2: per-axis products
  logic signed [PBW-1:0] s2_pb_r [3];
  logic        [SQW-1:0] s2_xx_r [3];
  logic signed [BXW-1:0] s2_bx_r [3];
  logic signed [XW-1:0]  s2_x_r  [3];
  logic                  s2_box_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_pb_r[i] <= PBW'(s1_p_r[i] * cb[i]);
        s2_xx_r[i] <= $unsigned(SQW'(s1_x_r[i] * s1_x_r[i]));
        s2_bx_r[i] <= BXW'(cb[i] * s1_x_r[i]);
        s2_x_r[i]  <= s1_x_r[i];
      end
      s2_box_r <= s1_box_r;
    end
  end

  // stage 3: sums, box, plane and sphere decided here
  logic signed [DW-1:0]  s3_dot_r;
  logic signed [XW-1:0]  s3_x_r [3];
  logic                  s3_early_r;
  logic signed [SQ_W-1:0] pl_sum;
  logic        [SSW-1:0]  sp_sum;
  logic        [SQ_W-1:0] sp_sq;
  logic                   early_nxt;

  always_comb begin
    pl_sum = SQ_W'(s2_pb_r[0]) + SQ_W'(s2_pb_r[1]) + SQ_W'(s2_pb_r[2])
           + SQ_W'($signed(r_out_r));
    sp_sum = SSW'(s2_xx_r[0]) + SSW'(s2_xx_r[1]) + SSW'(s2_xx_r[2]);
    sp_sq  = SQ_W'(sp_sum) << 16;
    case (kind_r)
      KIND_BOX:   early_nxt = s2_box_r;
      KIND_PLANE: early_nxt = !pl_sum[SQ_W-1];
      KIND_SPH:   early_nxt = (sp_sq <= r_osq_r) && (sp_sq >= SQ_W'(aux_r));
      default:    early_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_dot_r   <= DW'(s2_bx_r[0]) + DW'(s2_bx_r[1]) + DW'(s2_bx_r[2]);
      s3_x_r     <= s2_x_r;
      s3_early_r <= early_nxt;
    end
  end

  // stage 4: dot times axis scale as four partial products
  logic [DLO+AUX_HALF-1:0] s4_ll_r, s4_lh_r;
  logic [DHI+AUX_HALF-1:0] s4_hl_r, s4_hh_r;
  logic                    s4_neg_r;
  logic signed [XW-1:0]    s4_x_r [3];
  logic                    s4_early_r;
  logic [DLO-1:0]          d_lo;
  logic [DHI-1:0]          d_hi;
  logic [AUX_HALF-1:0]     a_lo, a_hi;

  assign d_lo = s3_dot_r[DLO-1:0];
  assign d_hi = s3_dot_r[DMW-1:DLO];
  assign a_lo = aux_r[AUX_HALF-1:0];
  assign a_hi = aux_r[AUX_W-1:AUX_HALF];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_ll_r    <= (DLO+AUX_HALF)'(d_lo * a_lo);
      s4_lh_r    <= (DLO+AUX_HALF)'(d_lo * a_hi);
      s4_hl_r    <= (DHI+AUX_HALF)'(d_hi * a_lo);
      s4_hh_r    <= (DHI+AUX_HALF)'(d_hi * a_hi);
      s4_neg_r   <= s3_dot_r[DW-1];
      s4_x_r     <= s3_x_r;
      s4_early_r <= s3_early_r;
    end
  end

  // stage 5: full product in Q.48
  logic [PW-1:0]        s5_p_r;
  logic                 s5_neg_r;
  logic signed [XW-1:0] s5_x_r [3];
  logic                 s5_early_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_p_r <= PW'(s4_ll_r) + (PW'(s4_lh_r) << AUX_HALF) + (PW'(s4_hl_r) << DLO)
              + (PW'(s4_hh_r) << (DLO + AUX_HALF));
      s5_neg_r   <= s4_neg_r;
      s5_x_r     <= s4_x_r;
      s5_early_r <= s4_early_r;
    end
  end

  // stage 6: range check of the fraction
  logic [T_W-1:0]       s6_t_r;
  logic                 s6_fail_r;
  logic signed [XW-1:0] s6_x_r [3];
  logic                 s6_early_r;
  logic                 aux_zero;
  logic                 over;

  assign aux_zero = (aux_r == '0);
  assign over     = s5_p_r > (PW'(1) << 48);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_t_r     <= aux_zero ? '0 : s5_p_r[48:16];
      s6_fail_r  <= !aux_zero && (s5_neg_r || over);
      s6_x_r     <= s5_x_r;
      s6_early_r <= s5_early_r;
    end
  end

  // stage 7: axis times fraction, radii times fraction
  logic signed [BTW-1:0] s7_bt_r [3];
  logic [2*RAD_W-1:0]    s7_ro_r, s7_ri_r;
  logic                  s7_tfull_r;
  logic                  s7_fail_r;
  logic signed [XW-1:0]  s7_x_r [3];
  logic                  s7_early_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int i = 0; i < 3; i++) begin
        s7_bt_r[i] <= BTW'(cb[i] * $signed({1'b0, s6_t_r}));
      end
      s7_ro_r    <= s6_t_r[RAD_W-1:0] * r_out_r;
      s7_ri_r    <= s6_t_r[RAD_W-1:0] * r_in_r;
      s7_tfull_r <= s6_t_r[T_W-1];
      s7_fail_r  <= s6_fail_r;
      s7_x_r     <= s6_x_r;
      s7_early_r <= s6_early_r;
    end
  end

  // stage 8: radial vector rounded to Q.12, ties upward; cone radii scaled by the fraction
  logic signed [QW-1:0] s8_q_r [3];
  logic [RAD_W-1:0]     s8_ro_r, s8_ri_r;
  logic                 s8_fail_r;
  logic                 s8_early_r;
  logic signed [VW-1:0] vr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vr[i] = VW'($signed({s7_x_r[i], 32'b0})) - VW'(s7_bt_r[i])
            + (VW'(1) << (RND_SH - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      for (int i = 0; i < 3; i++) begin
        s8_q_r[i] <= vr[i][VW-1:RND_SH];
      end
      if (kind_r == KIND_CONE) begin
        s8_ro_r <= s7_tfull_r ? r_out_r : s7_ro_r[2*RAD_W-1:RAD_W];
        s8_ri_r <= s7_tfull_r ? r_in_r  : s7_ri_r[2*RAD_W-1:RAD_W];
      end else begin
        s8_ro_r <= r_out_r;
        s8_ri_r <= r_in_r;
      end
      s8_fail_r  <= s7_fail_r;
      s8_early_r <= s7_early_r;
    end
  end

  // stage 9: squares
  logic [QQW-1:0]  s9_qq_r [3];
  logic [SQ_W-1:0] s9_hi_r, s9_lo_r;
  logic            s9_fail_r;
  logic            s9_early_r;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      for (int i = 0; i < 3; i++) begin
        s9_qq_r[i] <= $unsigned(QQW'(s8_q_r[i] * s8_q_r[i]));
      end
      s9_hi_r    <= (kind_r == KIND_CONE) ? s8_ro_r * s8_ro_r : r_osq_r;
      s9_lo_r    <= s8_ri_r * s8_ri_r;
      s9_fail_r  <= s8_fail_r;
      s9_early_r <= s8_early_r;
    end
  end

  // stage 10: radial bounds and final answer, this is the output register
  logic [SQ_W-1:0] rad_sq;
  logic            inside_r;
  logic            fin_nxt;

  always_comb begin
    rad_sq = (SQ_W'(s9_qq_r[0]) + SQ_W'(s9_qq_r[1]) + SQ_W'(s9_qq_r[2])) << 8;
    if (kind_r == KIND_CYL || kind_r == KIND_CONE) begin
      fin_nxt = !s9_fail_r && (rad_sq <= s9_hi_r) && (rad_sq >= s9_lo_r);
    end else begin
      fin_nxt = s9_early_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      inside_r <= fin_nxt;
    end
  end

  assign out_inside_res = inside_r;

endmodule

// ===== bench/tb_point_in_domain_test.sv =====
// self-checking bench for the point-in-domain test: directed and random points
// per domain kind, with a local predictor; depends on pid_pkg and the block
`timescale 1ns / 1ps

module tb_point_in_domain_test;
  import pid_pkg::*;

  localparam int CB = 21;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PT_W-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inside_res;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  point_in_domain_test #(.COORD_BITS(CB)) uut (.*);

  // local copy of the domain registers
  logic [2:0]        dom_kind = KIND_NONE;
  logic [PK_W-1:0]   dom_a = '0, dom_b = '0;
  logic [RAD_W-1:0]  dom_rout = '0, dom_rin = '0;
  logic [SQ_W-1:0]   dom_rosq = '0;
  logic [AUX_W-1:0]  dom_aux = '0;

  bit expected_inside[$];
  int mismatches = 0;
  int fail_seen = 0;

  function automatic logic signed [127:0] coord(logic [PK_W-1:0] p, int i);
    logic signed [CB-1:0] c;
    c = p[i*CB +: CB];
    return c;
  endfunction

  // Q.40 to Q.12, nearest, ties toward plus infinity
  function automatic logic signed [127:0] round_q12(logic signed [127:0] v);
    return (v + (128'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic bit point_inside(logic [PT_W-1:0] px, logic [PT_W-1:0] py,
                                      logic [PT_W-1:0] pz);
    logic signed [127:0] p[3], a[3], b[3], x[3];
    logic signed [127:0] dot, prod, q, v;
    logic [127:0] r, t, lo_sq, hi_sq, ro, ri;
    logic signed [CB-1:0] c;
    c = px; p[0] = c;
    c = py; p[1] = c;
    c = pz; p[2] = c;
    for (int i = 0; i < 3; i++) begin
      a[i] = coord(dom_a, i);
      b[i] = coord(dom_b, i);
      x[i] = p[i] - a[i];
    end
    case (dom_kind)
      KIND_BOX: begin
        for (int i = 0; i < 3; i++)
          if (p[i] < a[i] || p[i] > b[i]) return 1'b0;
        return 1'b1;
      end
      KIND_PLANE: begin
        dot = p[0]*b[0] + p[1]*b[1] + p[2]*b[2] + $signed({{96{dom_rout[31]}}, dom_rout});
        return dot >= 0;
      end
      KIND_SPH: begin
        r = (x[0]*x[0] + x[1]*x[1] + x[2]*x[2]) << 16;
        return r <= dom_rosq && r >= dom_aux;
      end
      KIND_CYL, KIND_CONE: begin
        dot = b[0]*x[0] + b[1]*x[1] + b[2]*x[2];
        t = 0;
        if (dom_aux != 0) begin
          if (dot < 0) return 1'b0;
          prod = dot * $signed({80'd0, dom_aux});
          if (prod > (128'sd1 <<< 48)) return 1'b0;
          t = prod >>> 16;
        end
        r = 0;
        for (int i = 0; i < 3; i++) begin
          v = (x[i] <<< 32) - b[i] * $signed(t);
          q = round_q12(v);
          r = r + q*q;
        end
        r = r << 8;
        if (dom_kind == KIND_CYL) begin
          hi_sq = dom_rosq;
          lo_sq = dom_rin * dom_rin;
        end else begin
          // radii shrink linearly toward the base
          ro = (t >= (128'd1 << 32)) ? dom_rout : (t * dom_rout) >> 32;
          ri = (t >= (128'd1 << 32)) ? dom_rin : (t * dom_rin) >> 32;
          hi_sq = ro * ro;
          lo_sq = ri * ri;
        end
        return r <= hi_sq && r >= lo_sq;
      end
      default: return 1'b0;
    endcase
  endfunction

  // register write, only while the pipeline is drained
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KIND:  dom_kind = val[2:0];
      REG_PT_A:  dom_a = val[PK_W-1:0];
      REG_PT_B:  dom_b = val[PK_W-1:0];
      REG_R_OUT: dom_rout = val[RAD_W-1:0];
      REG_R_IN:  dom_rin = val[RAD_W-1:0];
      REG_R_OSQ: dom_rosq = val;
      REG_AUX:   dom_aux = val[AUX_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [PK_W-1:0] pack(int x, int y, int z);
    logic [CB-1:0] cx, cy, cz;
    cx = CB'(x); cy = CB'(y); cz = CB'(z);
    return {cz, cy, cx};
  endfunction

  // one beat on the point channel, with burst gaps
  int burst_left = 0;
  task automatic send_point(int x, int y, int z);
    logic [PT_W-1:0] px, py, pz;
    int gap;
    px = PT_W'(x);
    py = PT_W'(y);
    pz = PT_W'(z);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    expected_inside.push_back(point_inside(px, py, pz));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_inside.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  function automatic int rnd_coord(int span);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom;
    if (sel == 1) return $urandom_range(0, 1) ? 'h0fffff : 'h100000;
    return $urandom_range(0, 2*span) - span;
  endfunction

  task automatic random_points(int n, int span, int cx, int cy, int cz);
    for (int i = 0; i < n; i++)
      send_point(cx + rnd_coord(span), cy + rnd_coord(span), cz + rnd_coord(span));
  endtask

  task automatic test_reset_kind();
    // after reset nothing is inside
    send_point(0, 0, 0);
    send_point(21'h0fffff, 21'h100000, 21'h1fffff);
    drain();
  endtask

  task automatic test_box();
    write_reg(REG_KIND, KIND_BOX);
    write_reg(REG_PT_A, pack(-100, -200, -300));
    write_reg(REG_PT_B, pack(100, 200, 300));
    send_point(-100, -200, -300);
    send_point(100, 200, 300);
    send_point(101, 0, 0);
    send_point(0, 0, -301);
    random_points(150, 400, 0, 0, 0);
    drain();
    // crossed corners never hold anything
    write_reg(REG_PT_A, pack(10, 0, 0));
    write_reg(REG_PT_B, pack(-10, 5, 5));
    send_point(0, 0, 0);
    random_points(40, 20, 0, 0, 0);
    drain();
    // extreme corners
    write_reg(REG_PT_A, {3{21'h100000}});
    write_reg(REG_PT_B, {3{21'h0fffff}});
    send_point(21'h100000, 21'h0fffff, 0);
    random_points(40, 1000000, 0, 0, 0);
    drain();
  endtask

  task automatic test_plane();
    write_reg(REG_KIND, KIND_PLANE);
    write_reg(REG_PT_B, pack(256, 0, 0));
    write_reg(REG_R_OUT, 32'hffff_0000);
    send_point(1, 0, 0);
    send_point(0, 0, 0);
    send_point(-1, 0, 0);
    random_points(120, 300, 0, 0, 0);
    drain();
    write_reg(REG_PT_B, {21'h0fffff, 21'h100000, 21'h0b5});
    write_reg(REG_R_OUT, 32'h8000_0000);
    random_points(120, 1048575, 0, 0, 0);
    drain();
    write_reg(REG_R_OUT, 32'h7fff_ffff);
    random_points(60, 1048575, 0, 0, 0);
    drain();
  endtask

  task automatic test_sphere();
    write_reg(REG_KIND, KIND_SPH);
    write_reg(REG_PT_A, pack(50, -50, 0));
    write_reg(REG_R_OSQ, 64'd100 << 32);  // radius 10
    write_reg(REG_AUX, 48'd25 << 32);     // inner radius 5
    send_point(50 + 2560, -50, 0);
    send_point(50 + 1280, -50, 0);
    send_point(50, -50, 0);
    random_points(200, 3000, 50, -50, 0);
    drain();
    write_reg(REG_R_OSQ, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_AUX, 48'hffff_ffff_ffff);
    random_points(100, 1048575, 0, 0, 0);
    drain();
    write_reg(REG_R_OSQ, 64'd9 << 32);  // inner bound above outer
    random_points(30, 3000, 50, -50, 0);
    drain();
  endtask

  task automatic test_axis(kind_t k);
    write_reg(REG_KIND, k);
    write_reg(REG_PT_A, pack(0, 0, 0));
    write_reg(REG_PT_B, pack(0, 0, 2560));           // length 10
    write_reg(REG_R_OUT, 32'd3 << 16);
    write_reg(REG_R_IN, 32'd1 << 16);
    write_reg(REG_R_OSQ, 64'd9 << 32);
    write_reg(REG_AUX, 48'd65536);                    // axis scale 2^-16 in Q.32
    send_point(0, 0, 0);
    send_point(0, 0, 2560);
    send_point(0, 0, 2561);
    send_point(512, 0, 1280);
    send_point(0, 0, -1);
    random_points(250, 1200, 0, 0, 1280);
    drain();
    // zero axis scale: only the radial bound decides
    write_reg(REG_AUX, 48'd0);
    random_points(80, 1200, 0, 0, 0);
    drain();
    write_reg(REG_PT_A, {$urandom, $urandom});
    write_reg(REG_PT_B, {$urandom, $urandom});
    write_reg(REG_R_OUT, 32'hffff_ffff);
    write_reg(REG_R_IN, 32'd0);
    write_reg(REG_AUX, {$urandom, $urandom});
    random_points(80, 1048575, 0, 0, 0);
    drain();
  endtask

  task automatic test_unused_kinds();
    for (int k = 5; k < 8; k++) begin
      write_reg(REG_KIND, k[2:0]);
      random_points(30, 1048575, 0, 0, 0);
      drain();
    end
  endtask

  // receiver stalls at random, on its own pattern
  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 3) == 0)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // compare each output beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_inside.size() == 0) begin
        fail_seen = 1;
        if (mismatches < 10) $display("unexpected beat, inside=%0b", out_inside_res);
        mismatches++;
      end else begin
        bit e;
        e = expected_inside.pop_front();
        if (out_inside_res !== e) begin
          fail_seen = 1;
          if (mismatches < 10)
            $display("inside mismatch: expected %0b got %0b", e, out_inside_res);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_kind();
    test_box();
    test_plane();
    test_sphere();
    test_axis(KIND_CYL);
    test_axis(KIND_CONE);
    test_unused_kinds();
    if (!fail_seen && expected_inside.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
